// File: rtl/skvt_pkg.sv
// ============================================================================
// Sorted key-value table package
// Shared types, codes and defaults for the sorted key-value table core.
// ============================================================================
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic               op;
        logic               compare;
        logic               update;
        logic               full;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               gt;
        logic               hit;
    } link_t;

endpackage

`default_nettype wire

// File: rtl/skvt_cell.sv
// ============================================================================
// Sorted key-value table cell
// Holds one table entry, flags it against the current beat and shifts it
// toward either neighbor on insert or delete.
// ============================================================================
`default_nettype none

module skvt_cell #(
    parameter int COUNT_W = 5,
    parameter int INDEX   = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire skvt_pkg::cmd_t       cmd,
    input  wire logic [COUNT_W-1:0]   count,
    input  wire skvt_pkg::link_t      left_in,
    input  wire skvt_pkg::link_t      right_in,
    output skvt_pkg::link_t           link_out
);

    logic [skvt_pkg::KEY_W-1:0]   key_reg;
    logic [skvt_pkg::KEY_W-1:0]   key_next;
    logic [skvt_pkg::VALUE_W-1:0] value_reg;
    logic [skvt_pkg::VALUE_W-1:0] value_next;
    logic                         gt_reg;
    logic                         gt_next;
    logic                         match_reg;
    logic                         match_next;
    logic                         live;
    logic                         at_end;
    logic                         hit;

    assign live   = COUNT_W'(INDEX) < count;
    assign at_end = count == COUNT_W'(INDEX);
    assign hit    = left_in.hit | match_reg;

    assign link_out.key   = key_reg;
    assign link_out.value = value_reg;
    assign link_out.gt    = gt_reg;
    assign link_out.hit   = hit;

    always_comb
    begin
        gt_next    = gt_reg;
        match_next = match_reg;
        if (cmd.compare)
        begin
            gt_next    = live && ($signed(key_reg) > $signed(cmd.key));
            match_next = live && (key_reg == cmd.key) && (value_reg == cmd.value);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.update)
        begin
            if (cmd.op == skvt_pkg::OP_INSERT)
            begin
                if (!cmd.full)
                begin
                    if (left_in.gt)
                    begin
                        key_next   = left_in.key;
                        value_next = left_in.value;
                    end
                    else if (gt_reg || at_end)
                    begin
                        key_next   = cmd.key;
                        value_next = cmd.value;
                    end
                end
            end
            else if (hit)
            begin
                key_next   = right_in.key;
                value_next = right_in.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            gt_reg    <= gt_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// File: rtl/sorted_key_value_table_core.sv
// ============================================================================
// Sorted key-value table core
// Keeps up to CAPACITY key-value pairs in ascending signed key order in a
// row of cells and answers each insert or delete beat with status and count.
// ============================================================================
// Each item passes through the idle (accept), compare and shift states in
// that order; s_tready is high only in the idle state, so a new item is not
// accepted until the core has finished the shift state for the last one.
// A stalled output holds the shift cycle until the result register frees up.
// Reset clears the entry count and the control state; entry contents are not
// cleared and there is no clearing pass.
`default_nettype none

module sorted_key_value_table_core #(
    parameter int CAPACITY = skvt_pkg::CAPACITY
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // operation, entry_key, entry_value, zero fill
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status, entry_count, zero fill
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic                             op_reg;
    logic [skvt_pkg::KEY_W-1:0]       key_reg;
    logic [skvt_pkg::VALUE_W-1:0]     value_reg;
    logic [COUNT_W-1:0]               count_reg;
    logic [COUNT_W-1:0]               count_next;
    logic                             m_tvalid_reg;
    logic                             m_tvalid_next;
    logic [skvt_pkg::STATUS_W-1:0]    status_reg;
    logic [skvt_pkg::STATUS_W-1:0]    status_next;
    logic [COUNT_W+skvt_pkg::COUNT_OUT_W-1:0] count_wide;
    logic                             accept;
    logic                             full;
    logic                             found;
    logic                             do_update;
    skvt_pkg::cmd_t                   cmd;
    skvt_pkg::link_t                  links [CAPACITY];

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign full      = count_reg == COUNT_W'(CAPACITY);
    assign do_update = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);
    assign found     = links[CAPACITY-1].hit;

    assign cmd.op      = op_reg;
    assign cmd.compare = state_reg == ST_CMP;
    assign cmd.update  = do_update;
    assign cmd.full    = full;
    assign cmd.key     = key_reg;
    assign cmd.value   = value_reg;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            skvt_pkg::link_t left_link;
            skvt_pkg::link_t right_link;
            if (i == 0)
            begin : g_first
                assign left_link = '0;
            end
            else
            begin : g_left
                assign left_link = links[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_link = '0;
            end
            else
            begin : g_right
                assign right_link = links[i+1];
            end
            skvt_cell #(
                .COUNT_W (COUNT_W),
                .INDEX   (i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .count    (count_reg),
                .left_in  (left_link),
                .right_in (right_link),
                .link_out (links[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (do_update)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    if (op_reg == skvt_pkg::OP_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = skvt_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            status_next = skvt_pkg::STATUS_DONE;
                            count_next  = count_reg + COUNT_W'(1);
                        end
                    end
                    else if (found)
                    begin
                        status_next = skvt_pkg::STATUS_DONE;
                        count_next  = count_reg - COUNT_W'(1);
                    end
                    else
                    begin
                        status_next = skvt_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            op_reg    <= s_tdata[0];
            key_reg   <= s_tdata[32:1];
            value_reg <= s_tdata[64:33];
        end
    end

    assign count_wide = {{skvt_pkg::COUNT_OUT_W{1'b0}}, count_reg};
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {1'b0, count_wide[skvt_pkg::COUNT_OUT_W-1:0], status_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_accept_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CMP)
        else $error("Accepted beat did not move to the compare cycle.");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg == skvt_pkg::STATUS_FULL) |-> full)
        else $error("Full status reported while the table has room.");

    a_count_changes_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(do_update))
        else $error("Entry count changed outside the shift cycle.");

    a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        do_update |=> m_tvalid)
        else $error("Shift cycle did not produce a result beat.");

endmodule

`default_nettype wire
